// ===== hdl/cossim_pkg.sv =====
// Shared widths and result type for the cosine similarity accumulator.
package cossim_pkg;

   localparam int MULT_WIDTH   = 32;
   localparam int RESULT_WIDTH = 16;

   typedef struct packed {
      logic [RESULT_WIDTH-1:0] similarity;
      logic                    undefined;
   } result_type;

endpackage

// ===== hdl/cosine_similarity_accumulator_top.sv =====
// Cosine similarity accumulator: input handshake, core and registered result.
//
// The req_ channel carries element pairs (reference and row sample, signed
// Q4.11) with req_row_last on a row's final pair. An item is taken when
// req_valid is high and req_stall is low. Each pair is handled in an accept
// state and three passes through the single shared 32x32 multiplier
// (dot product, both squares), each followed by its accumulate. On the last
// pair the block then forms the two wide products in limbs and runs a
// 16-bit, bit-at-a-time quotient search (three limb multiplies and one
// 128-bit compare-subtract per bit), then writes the result.
// The rsp_ channel presents similarity (signed Q1.15, saturated) and the
// undefined flag in the cycle after the write. The result sits in an output
// register: while rsp_stall is high it holds, and the core keeps taking new
// pairs of the next row; a second finished row waits in the core until the
// register frees.
// Reset (synchronous, active high) clears all three accumulators and drops
// rsp_valid.
module cosine_similarity_accumulator_top #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_ref_value,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_row_value,
   input  logic                                  req_row_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [cossim_pkg::RESULT_WIDTH-1:0] rsp_similarity_value,
   output logic                                  rsp_undefined_flag
);

   logic                   busy;
   logic                   item_valid;
   logic                   out_free;
   logic                   result_valid;
   cossim_pkg::result_type result;

   logic                   rsp_valid_ff, rsp_valid_in;
   cossim_pkg::result_type rsp_data_ff, rsp_data_in;

   assign req_stall  = busy;
   assign item_valid = req_valid && !busy;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   cossim_core #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (item_valid),
      .ref_value    (req_ref_value),
      .row_value    (req_row_value),
      .row_last     (req_row_last),
      .out_free     (out_free),
      .busy         (busy),
      .result_valid (result_valid),
      .result       (result)
   );

   // load a new item when the core finishes, drop valid once taken
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (result_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_similarity_value = rsp_data_ff.similarity;
   assign rsp_undefined_flag   = rsp_data_ff.undefined;

endmodule

// ===== hdl/cossim_mult.sv =====
// Shared unsigned multiplier with a registered product.
module cossim_mult (
   input  logic                                 clock,
   input  logic [cossim_pkg::MULT_WIDTH-1:0]    mul_a,
   input  logic [cossim_pkg::MULT_WIDTH-1:0]    mul_b,
   output logic [2*cossim_pkg::MULT_WIDTH-1:0]  product_ff
);

   logic [2*cossim_pkg::MULT_WIDTH-1:0] product_in;

   assign product_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

// ===== hdl/cossim_core.sv =====
// Sequencer and datapath: accumulation, end-of-row products and bitwise ratio search.
module cossim_core #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           item_valid,
   input  logic signed [SAMPLE_WIDTH-1:0] ref_value,
   input  logic signed [SAMPLE_WIDTH-1:0] row_value,
   input  logic                           row_last,
   input  logic                           out_free,
   output logic                           busy,
   output logic                           result_valid,
   output cossim_pkg::result_type         result
);

   localparam int MW = cossim_pkg::MULT_WIDTH;
   localparam int RW = cossim_pkg::RESULT_WIDTH;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_DOT_MUL  = 4'd1;
   localparam logic [3:0] ST_DOT_ADD  = 4'd2;
   localparam logic [3:0] ST_REF_ADD  = 4'd3;
   localparam logic [3:0] ST_ROW_ADD  = 4'd4;
   localparam logic [3:0] ST_FIN_MUL  = 4'd5;
   localparam logic [3:0] ST_FIN_ADD  = 4'd6;
   localparam logic [3:0] ST_SRCH_MUL = 4'd7;
   localparam logic [3:0] ST_SRCH_ADD = 4'd8;
   localparam logic [3:0] ST_SRCH_CMP = 4'd9;
   localparam logic [3:0] ST_WRITE    = 4'd10;

   localparam logic [2:0] STEP_P_DONE = 3'd3;
   localparam logic [2:0] STEP_T_DONE = 3'd7;
   localparam logic [1:0] LIMB_TOP    = 2'd2;
   localparam logic [3:0] BIT_TOP     = 4'd15;

   localparam logic [49:0] DOT_HI   = 50'h0_7FFF_FFFF_FFFF;
   localparam logic [49:0] DOT_LO   = 50'h3_8000_0000_0000;
   localparam logic [46:0] SQ_MAX   = 47'h7FFF_FFFF_FFFF;
   localparam logic [RW-1:0] Q_FULL = 16'h8000;
   localparam logic [RW-1:0] Q_POS  = 16'h7FFF;

   // candidate term (2q + 2^k) * 2^k for trying bit k of the quotient
   function automatic logic [31:0] cand_of(input logic [15:0] q, input logic [3:0] k);
      cand_of = (32'(q) << (k + 5'd1)) | (32'd1 << {k, 1'b0});
   endfunction

   logic [3:0]              state_ff, state_in;
   logic [SAMPLE_WIDTH-1:0] mag_ref_ff, mag_ref_in;
   logic [SAMPLE_WIDTH-1:0] mag_row_ff, mag_row_in;
   logic                    neg_ff, neg_in;
   logic                    last_ff, last_in;
   logic [47:0]             dot_ff, dot_in;
   logic [46:0]             ref_sq_ff, ref_sq_in;
   logic [46:0]             row_sq_ff, row_sq_in;
   logic [2:0]              step_ff, step_in;
   logic [1:0]              limb_ff, limb_in;
   logic [3:0]              bit_ff, bit_in;
   logic [15:0]             q_ff, q_in;
   logic [31:0]             cand_ff, cand_in;
   logic [127:0]            acc_ff, acc_in;
   logic [95:0]             p_ff, p_in;
   logic [127:0]            rem_ff, rem_in;

   logic [MW-1:0]   mul_a, mul_b;
   logic [2*MW-1:0] product;

   logic [47:0]  prod48;
   logic [49:0]  dot_term, dot_sum;
   logic [47:0]  ref_sum, row_sum;
   logic [47:0]  dot_mag;
   logic [47:0]  x_src, y_src;
   logic         fin_hi_x, fin_hi_y, fin_shift;
   logic [MW-1:0] fin_x, fin_y, p_limb;
   logic [127:0] fin_sum, srch_sum;
   logic         fits;
   logic [15:0]  q_try;
   logic [RW-1:0] q_clamp, sim_value;
   logic         undef;

   cossim_mult u_mult (
      .clock      (clock),
      .mul_a      (mul_a),
      .mul_b      (mul_b),
      .product_ff (product)
   );

   assign prod48   = product[47:0];
   assign dot_term = neg_ff ? (50'd0 - {2'b00, prod48}) : {2'b00, prod48};
   assign dot_sum  = {{2{dot_ff[47]}}, dot_ff} + dot_term;
   assign ref_sum  = {1'b0, ref_sq_ff} + prod48;
   assign row_sum  = {1'b0, row_sq_ff} + prod48;
   assign dot_mag  = dot_ff[47] ? (~dot_ff + 48'd1) : dot_ff;

   // limb pairs of the two end-of-row products, high diagonal first
   assign fin_hi_x  = (step_ff[1:0] == 2'd0) || (step_ff[1:0] == 2'd1);
   assign fin_hi_y  = (step_ff[1:0] == 2'd0) || (step_ff[1:0] == 2'd2);
   assign fin_shift = (step_ff[1:0] != 2'd2);
   assign x_src     = step_ff[2] ? dot_mag : {1'b0, ref_sq_ff};
   assign y_src     = step_ff[2] ? dot_mag : {1'b0, row_sq_ff};
   assign fin_x     = fin_hi_x ? MW'(x_src[47:32]) : x_src[31:0];
   assign fin_y     = fin_hi_y ? MW'(y_src[47:32]) : y_src[31:0];
   assign fin_sum   = (fin_shift ? {acc_ff[95:0], 32'd0} : acc_ff) + 128'(product);
   assign srch_sum  = {acc_ff[95:0], 32'd0} + 128'(product);
   assign fits      = (acc_ff <= rem_ff);
   assign q_try     = fits ? (q_ff | (16'd1 << bit_ff)) : q_ff;

   always_comb begin
      unique case (limb_ff)
         2'd2:    p_limb = p_ff[95:64];
         2'd1:    p_limb = p_ff[63:32];
         default: p_limb = p_ff[31:0];
      endcase
   end

   always_comb begin
      unique case (state_ff)
         ST_DOT_MUL: begin
            mul_a = MW'(mag_ref_ff);
            mul_b = MW'(mag_row_ff);
         end
         ST_DOT_ADD: begin
            mul_a = MW'(mag_ref_ff);
            mul_b = MW'(mag_ref_ff);
         end
         ST_REF_ADD: begin
            mul_a = MW'(mag_row_ff);
            mul_b = MW'(mag_row_ff);
         end
         ST_FIN_MUL: begin
            mul_a = fin_x;
            mul_b = fin_y;
         end
         ST_SRCH_MUL: begin
            mul_a = cand_ff;
            mul_b = p_limb;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // final sign, clamp to +1.0 and saturate to the Q1.15 range
   always_comb begin
      undef   = (ref_sq_ff == 47'd0) || (row_sq_ff == 47'd0);
      q_clamp = (q_ff > Q_FULL) ? Q_FULL : q_ff;
      if (undef) begin
         sim_value = '0;
      end else if (dot_ff[47]) begin
         sim_value = RW'(0) - q_clamp;
      end else begin
         sim_value = (q_clamp == Q_FULL) ? Q_POS : q_clamp;
      end
   end

   always_comb begin
      state_in   = state_ff;
      mag_ref_in = mag_ref_ff;
      mag_row_in = mag_row_ff;
      neg_in     = neg_ff;
      last_in    = last_ff;
      dot_in     = dot_ff;
      ref_sq_in  = ref_sq_ff;
      row_sq_in  = row_sq_ff;
      step_in    = step_ff;
      limb_in    = limb_ff;
      bit_in     = bit_ff;
      q_in       = q_ff;
      cand_in    = cand_ff;
      acc_in     = acc_ff;
      p_in       = p_ff;
      rem_in     = rem_ff;
      result_valid = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               mag_ref_in = ref_value[SAMPLE_WIDTH-1] ? (~ref_value + 1'b1) : ref_value;
               mag_row_in = row_value[SAMPLE_WIDTH-1] ? (~row_value + 1'b1) : row_value;
               neg_in     = ref_value[SAMPLE_WIDTH-1] ^ row_value[SAMPLE_WIDTH-1];
               last_in    = row_last;
               state_in   = ST_DOT_MUL;
            end
         end
         ST_DOT_MUL: begin
            state_in = ST_DOT_ADD;
         end
         ST_DOT_ADD: begin
            priority if ($signed(dot_sum) > $signed(DOT_HI)) begin
               dot_in = DOT_HI[47:0];
            end else if ($signed(dot_sum) < $signed(DOT_LO)) begin
               dot_in = DOT_LO[47:0];
            end else begin
               dot_in = dot_sum[47:0];
            end
            state_in = ST_REF_ADD;
         end
         ST_REF_ADD: begin
            ref_sq_in = ref_sum[47] ? SQ_MAX : ref_sum[46:0];
            state_in  = ST_ROW_ADD;
         end
         ST_ROW_ADD: begin
            row_sq_in = row_sum[47] ? SQ_MAX : row_sum[46:0];
            if (last_ff) begin
               acc_in   = '0;
               step_in  = '0;
               state_in = ST_FIN_MUL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FIN_MUL: begin
            state_in = ST_FIN_ADD;
         end
         ST_FIN_ADD: begin
            priority if (step_ff == STEP_P_DONE) begin
               p_in     = fin_sum[95:0];
               acc_in   = '0;
               step_in  = step_ff + 3'd1;
               state_in = ST_FIN_MUL;
            end else if (step_ff == STEP_T_DONE) begin
               // scale the squared dot by 2^30 to match q^2 in Q15
               rem_in   = {fin_sum[97:0], 30'd0};
               acc_in   = '0;
               bit_in   = BIT_TOP;
               limb_in  = LIMB_TOP;
               q_in     = '0;
               cand_in  = cand_of(16'd0, BIT_TOP);
               state_in = ST_SRCH_MUL;
            end else begin
               acc_in   = fin_sum;
               step_in  = step_ff + 3'd1;
               state_in = ST_FIN_MUL;
            end
         end
         ST_SRCH_MUL: begin
            state_in = ST_SRCH_ADD;
         end
         ST_SRCH_ADD: begin
            acc_in = srch_sum;
            if (limb_ff == 2'd0) begin
               state_in = ST_SRCH_CMP;
            end else begin
               limb_in  = limb_ff - 2'd1;
               state_in = ST_SRCH_MUL;
            end
         end
         ST_SRCH_CMP: begin
            // keep the bit when the grown square still fits the remainder
            if (fits) begin
               rem_in = rem_ff - acc_ff;
            end
            q_in   = q_try;
            acc_in = '0;
            if (bit_ff == 4'd0) begin
               state_in = ST_WRITE;
            end else begin
               bit_in   = bit_ff - 4'd1;
               limb_in  = LIMB_TOP;
               cand_in  = cand_of(q_try, bit_ff - 4'd1);
               state_in = ST_SRCH_MUL;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               result_valid = 1'b1;
               dot_in       = '0;
               ref_sq_in    = '0;
               row_sq_in    = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy              = (state_ff != ST_IDLE);
   assign result.similarity = sim_value;
   assign result.undefined  = undef;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         dot_ff    <= '0;
         ref_sq_ff <= '0;
         row_sq_ff <= '0;
      end else begin
         state_ff  <= state_in;
         dot_ff    <= dot_in;
         ref_sq_ff <= ref_sq_in;
         row_sq_ff <= row_sq_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ref_ff <= mag_ref_in;
      mag_row_ff <= mag_row_in;
      neg_ff     <= neg_in;
      last_ff    <= last_in;
      step_ff    <= step_in;
      limb_ff    <= limb_in;
      bit_ff     <= bit_in;
      q_ff       <= q_in;
      cand_ff    <= cand_in;
      acc_ff     <= acc_in;
      p_ff       <= p_in;
      rem_ff     <= rem_in;
   end

endmodule

// ===== sim/tb_cosine_similarity_accumulator_top.sv =====
// Testbench for the cosine similarity accumulator: streamed rows checked against a predictor.
`timescale 1ns / 1ps

module tb_cosine_similarity_accumulator_top;

   localparam int SAMPLE_BITS    = 16;
   localparam int SCORE_BITS     = cossim_pkg::RESULT_WIDTH;
   localparam int RANDOM_PAIRS   = 850;
   localparam int HOLDOFF_CYCLES = 1500;
   localparam int DRAIN_CYCLES   = 400;

   localparam longint          DOT_TOP    = (64'sd1 <<< 47) - 1;
   localparam longint          DOT_BOTTOM = -DOT_TOP - 1;
   localparam longint unsigned SQ_TOP     = (64'd1 << 47) - 1;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] ref_sample;
      logic signed [SAMPLE_BITS-1:0] row_sample;
      logic                          row_last;
      logic                          drain_first;
   } pair_item_type;

   typedef struct {
      logic signed [SCORE_BITS-1:0] similarity;
      logic                         undefined;
   } score_type;

   typedef enum int {
      STYLE_WIDE,
      STYLE_TINY,
      STYLE_EDGE,
      STYLE_ZERO_REF,
      STYLE_ZERO_ROW,
      STYLE_OPPOSED,
      STYLE_ALIGNED
   } row_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                 req_valid     = 1'b0;
   logic                                 req_stall;
   logic signed [SAMPLE_BITS-1:0]        req_ref_value = '0;
   logic signed [SAMPLE_BITS-1:0]        req_row_value = '0;
   logic                                 req_row_last  = 1'b0;
   logic                                 rsp_valid;
   logic                                 rsp_stall     = 1'b0;
   logic signed [SCORE_BITS-1:0]         rsp_similarity_value;
   logic                                 rsp_undefined_flag;

   pair_item_type pending_pairs[$];
   score_type     expected_scores[$];

   // predictor copy of the accumulators
   logic signed [47:0] dot_acc    = '0;
   logic [46:0]        ref_sq_acc = '0;
   logic [46:0]        row_sq_acc = '0;

   int            failures     = 0;
   int            results_seen = 0;
   pair_item_type next_pair;
   score_type     want;
   int            burst_left;
   int            gap_left;
   int            hold_left;
   bit            hold_done    = 1'b0;
   int            stall_mode   = 0;
   int            stall_phase  = 0;

   cosine_similarity_accumulator_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_ref_value        (req_ref_value),
      .req_row_value        (req_row_value),
      .req_row_last         (req_row_last),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_similarity_value (rsp_similarity_value),
      .rsp_undefined_flag   (rsp_undefined_flag)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [46:0] square_sum_add(logic [46:0] acc,
                                                  logic signed [SAMPLE_BITS-1:0] s);
      longint unsigned total;
      total = 64'(acc) + 64'(longint'(s) * longint'(s));
      return (total > SQ_TOP) ? SQ_TOP[46:0] : total[46:0];
   endfunction

   // largest q in 0..32768 with q * sqrt(rsq * wsq) <= 32768 * |dot|, signed and clamped
   function automatic score_type cosine_score(logic signed [47:0] dot, logic [46:0] rsq,
                                              logic [46:0] wsq);
      logic [47:0]  mag;
      logic [127:0] cross_prod;
      logic [127:0] scaled_dot;
      int unsigned  lo;
      int unsigned  hi;
      int unsigned  mid;
      score_type    r;
      if (rsq == 0 || wsq == 0) begin
         r.similarity = '0;
         r.undefined  = 1'b1;
         return r;
      end
      mag        = dot[47] ? 48'(-dot) : 48'(dot);
      cross_prod = 128'(rsq) * 128'(wsq);
      scaled_dot = (128'(mag) * 128'(mag)) << 30;
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         if (cross_prod * 128'(mid * mid) <= scaled_dot)
            lo = mid;
         else
            hi = mid - 1;
      end
      r.undefined = 1'b0;
      if (dot[47])
         r.similarity = 16'(-lo);
      else
         r.similarity = (lo > 32767) ? 16'sh7FFF : 16'(lo);
      return r;
   endfunction

   function automatic void fold_pair(logic signed [SAMPLE_BITS-1:0] a,
                                     logic signed [SAMPLE_BITS-1:0] b, logic last);
      longint d;
      d = longint'(dot_acc) + longint'(a) * longint'(b);
      if (d > DOT_TOP)
         d = DOT_TOP;
      else if (d < DOT_BOTTOM)
         d = DOT_BOTTOM;
      dot_acc    = d[47:0];
      ref_sq_acc = square_sum_add(ref_sq_acc, a);
      row_sq_acc = square_sum_add(row_sq_acc, b);
      if (last) begin
         expected_scores.push_back(cosine_score(dot_acc, ref_sq_acc, row_sq_acc));
         dot_acc    = '0;
         ref_sq_acc = '0;
         row_sq_acc = '0;
      end
   endfunction

   task automatic push_pair(logic signed [SAMPLE_BITS-1:0] a,
                            logic signed [SAMPLE_BITS-1:0] b, logic last,
                            logic drain = 1'b0);
      pair_item_type p;
      p.ref_sample  = a;
      p.row_sample  = b;
      p.row_last    = last;
      p.drain_first = drain;
      pending_pairs.push_back(p);
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] any_sample(row_style_type style);
      case (style)
         STYLE_TINY: return 16'($urandom_range(0, 31) - 16);
         STYLE_EDGE: begin
            case ($urandom_range(0, 4))
               0:       return 16'sh8000;
               1:       return 16'sh7FFF;
               2:       return -16'sd1;
               3:       return 16'sd1;
               default: return 16'sd0;
            endcase
         end
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic add_random_row(int len, row_style_type style, logic drain);
      logic signed [SAMPLE_BITS-1:0] a;
      logic signed [SAMPLE_BITS-1:0] b;
      int                            target;
      for (int i = 0; i < len; i++) begin
         case (style)
            STYLE_ZERO_REF: begin
               a = '0;
               b = 16'($urandom);
            end
            STYLE_ZERO_ROW: begin
               a = 16'($urandom);
               b = '0;
            end
            STYLE_ALIGNED, STYLE_OPPOSED: begin
               a      = 16'($urandom);
               target = (style == STYLE_ALIGNED) ? int'(a) : -int'(a);
               target = target + int'($urandom_range(0, 64)) - 32;
               if (target > 32767)
                  target = 32767;
               else if (target < -32768)
                  target = -32768;
               b = 16'(target);
            end
            default: begin
               a = any_sample(style);
               b = any_sample(style);
            end
         endcase
         push_pair(a, b, i == len - 1, drain && i == 0);
      end
   endtask

   // sender: bursts of random length with random gaps; hold a marked item until drained
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = 8;
         gap_left   = 0;
      end else begin
         if (req_valid && !req_stall)
            fold_pair(req_ref_value, req_row_value, req_row_last);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_pairs.size() == 0 ||
                         (pending_pairs[0].drain_first && expected_scores.size() != 0)) begin
               req_valid <= 1'b0;
            end else begin
               next_pair = pending_pairs.pop_front();
               req_ref_value <= next_pair.ref_sample;
               req_row_value <= next_pair.row_sample;
               req_row_last  <= next_pair.row_last;
               req_valid     <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                          : $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end
            end
         end
      end
   end

   // receiver: stall pattern redrawn from four modes at intervals; one long holdoff to back up the block
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (!hold_done && results_seen >= 20) begin
            hold_left = HOLDOFF_CYCLES;
            hold_done = 1'b1;
         end
         stall_phase++;
         if (stall_phase % 256 == 0)
            stall_mode = $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ((stall_phase % 7) < 3);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_scores.size() == 0) begin
            $display("%0t: unexpected result: similarity %0d undefined %0b", $time,
                     rsp_similarity_value, rsp_undefined_flag);
            failures++;
         end else begin
            want = expected_scores.pop_front();
            if (rsp_similarity_value !== want.similarity) begin
               $display("%0t: similarity mismatch: expected %0d, actual %0d", $time,
                        want.similarity, rsp_similarity_value);
               failures++;
            end
            if (rsp_undefined_flag !== want.undefined) begin
               $display("%0t: undefined flag mismatch: expected %0b, actual %0b", $time,
                        want.undefined, rsp_undefined_flag);
               failures++;
            end
            results_seen++;
         end
      end
   end

   initial begin
      int            random_pairs;
      int            rows_made;
      int            row_len;
      int            pick;
      row_style_type style;

      // full scale both ways, including the minimum sample
      push_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
      push_pair(16'sh8000, 16'sh8000, 1'b1);
      push_pair(16'sh8000, 16'sh7FFF, 1'b1);
      push_pair(-16'sd1, -16'sd1, 1'b1);
      push_pair(16'sd1, -16'sd1, 1'b1);
      // zero magnitude on either side or both
      push_pair(16'sd0, 16'sd5, 1'b1);
      push_pair(16'sd7, 16'sd0, 1'b1);
      push_pair(16'sd0, 16'sd0, 1'b1);
      push_pair(16'sd0, 16'sh8000, 1'b0);
      push_pair(16'sd0, 16'sh7FFF, 1'b1);
      // orthogonal row: dot is zero, sums are not
      push_pair(16'sd1, 16'sd0, 1'b0);
      push_pair(16'sd0, 16'sd1, 1'b1);
      // mixed extremes
      push_pair(16'sh7FFF, 16'sh8000, 1'b0);
      push_pair(-16'sd1, 16'sd1, 1'b0);
      push_pair(16'sd1, -16'sd1, 1'b0);
      push_pair(16'sh8000, 16'sh7FFF, 1'b1);
      // alternating bit patterns, then a nearly aligned row
      push_pair(16'sh5555, 16'shAAAA, 1'b0);
      push_pair(16'shAAAA, 16'sh5555, 1'b0);
      push_pair(16'sh00FF, 16'shFF00, 1'b1);
      push_pair(16'sh1234, 16'sh1234, 1'b0);
      push_pair(16'sh0800, 16'sh0801, 1'b1);

      random_pairs = 0;
      rows_made    = 0;
      while (random_pairs < RANDOM_PAIRS) begin
         row_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         pick    = $urandom_range(0, 9);
         style   = (pick > 6) ? STYLE_ALIGNED : row_style_type'(pick);
         add_random_row(row_len, style, rows_made == 40);
         random_pairs += row_len;
         rows_made++;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_pairs.size() != 0 || req_valid || expected_scores.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0 && expected_scores.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #40000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/cossim_pkg.sv
hdl/cossim_mult.sv
hdl/cossim_core.sv
hdl/cosine_similarity_accumulator_top.sv
sim/tb_cosine_similarity_accumulator_top.sv
